### hw/rtl/ddlw_pkg.sv
package ddlw_pkg;

    localparam logic [7:0] START_BYTE = 8'd127;
    localparam logic [7:0] END_BYTE   = 8'd126;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_SHAPE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT = 2'd3;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic REG_LOSS_LIMIT  = 1'b0;
    localparam logic REG_SEQ_MODULUS = 1'b1;

    localparam logic [7:0] LOSS_LIMIT_RESET  = 8'd20;
    localparam logic [8:0] SEQ_MODULUS_RESET = 9'd100;

    typedef struct packed {
        logic take;
        logic finish;
        logic timeout;
        logic rd_en;
        logic load_word;
        logic load_status;
    } ddlw_cmd_t;

    typedef struct packed {
        logic more_words;
        logic out_free;
    } ddlw_stat_t;

endpackage

### hw/rtl/datagram_deframer_with_link_watch_core.sv
// Datagram deframer with link watch. Bytes of a datagram arrive on the slave stream, with
// tlast on the final byte of each datagram and tuser high for a receive-timeout word. Each
// frame must be four 127 bytes, a sequence byte, a length byte, the payload as little-endian
// 32-bit words, then four 126 bytes, filling the datagram exactly. A byte is taken every
// cycle while a datagram is being received. At the end of a datagram the payload words of a
// valid frame are released from the word memory, each word needing a registered memory read
// and then a load of the output register, which waits while the output is held, followed by
// one status word with tlast set; no further byte is taken until the status word is loaded.
// The status word reports validity, error code, sequence gap, connection, the bad-event count
// and the safe-stop flag. Configuration writes are taken at any time and must only be issued
// while the block is idle.
module datagram_deframer_with_link_watch_core #(
    parameter int BUF_BYTES = 256,
    parameter int MAX_WORDS = 61
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // payload_word [31:0], frame_valid [32], error_code [34:33],
                                   // sequence_gap [35], sequence_number [43:36],
                                   // connected [44], bad_count [52:45], safe_stop [53]
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    ddlw_pkg::ddlw_cmd_t  cmd;
    ddlw_pkg::ddlw_stat_t stat;

    assign cfg_ready = 1'b1;

    ddlw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ddlw_datapath #(
        .BUF_BYTES (BUF_BYTES),
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .byte_in   (s_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### hw/rtl/ddlw_ctrl.sv
module ddlw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    input  logic                s_tuser,
    output logic                s_tready,
    input  ddlw_pkg::ddlw_stat_t stat,
    output ddlw_pkg::ddlw_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_RX,
        S_FETCH,
        S_WORD,
        S_STATUS
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            S_RX:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.timeout = 1'b1;
                        state_next  = S_FETCH;
                        ready_next  = 1'b0;
                    end
                    else if (s_tlast)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_FETCH;
                        ready_next = 1'b0;
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                if (stat.more_words)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WORD;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_WORD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = S_RX;
                    ready_next      = 1'b1;
                end
            end
            default:
            begin
                state_next = S_RX;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RX;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

### hw/rtl/ddlw_datapath.sv
module ddlw_datapath #(
    parameter int BUF_BYTES = 256,
    parameter int MAX_WORDS = 61
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddlw_pkg::ddlw_cmd_t  cmd,
    output ddlw_pkg::ddlw_stat_t stat,
    input  logic [7:0]           byte_in,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [55:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);

    logic [8:0]  pos_reg;
    logic [7:0]  len_reg;
    logic [7:0]  seq_reg;
    logic        shape_ok_reg;
    logic        end_ok_reg;
    logic [23:0] asm_reg;

    logic [31:0] mem [MAX_WORDS];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [CW-1:0] words_left_reg;

    logic [7:0]  loss_limit_reg;
    logic [8:0]  seq_mod_reg;
    logic [7:0]  last_seq_reg;
    logic        link_up_reg;
    logic [7:0]  bad_reg;

    logic        st_valid_reg;
    logic [1:0]  st_code_reg;
    logic        st_gap_reg;
    logic [7:0]  st_seq_reg;
    logic        st_conn_reg;
    logic [7:0]  st_bad_reg;
    logic        st_stop_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic        out_last_reg;
    logic [53:0] out_data_reg;

    logic        byte_cmd;
    logic [8:0]  p;
    logic [8:0]  p_rel;
    logic        in_payload;
    logic        in_trailer;
    logic [1:0]  k;
    logic [6:0]  w;
    logic        wr_en;
    logic [23:0] asm_next;

    logic        shape_ok_n;
    logic        end_ok_n;
    logic [7:0]  len_n;
    logic [7:0]  seq_n;
    logic [9:0]  n;
    logic [1:0]  code;
    logic        frame_ok;
    logic [8:0]  expected;
    logic        gap;
    logic [7:0]  bad_inc;
    logic [7:0]  bad_new;
    logic        link_new;

    assign byte_cmd   = cmd.take | cmd.finish;
    assign p          = pos_reg - 9'd6;
    assign in_payload = (pos_reg >= 9'd6) && (p < {1'b0, len_reg});
    assign p_rel      = p - {1'b0, len_reg};
    assign in_trailer = (pos_reg >= 9'd6) && !in_payload && (p_rel < 9'd4);
    assign k          = p[1:0];
    assign w          = p[8:2];
    assign wr_en      = byte_cmd && in_payload && (k == 2'd3) && (w < 7'(MAX_WORDS));

    always_comb
    begin
        asm_next = asm_reg;
        case (k)
            2'd0:    asm_next = {16'd0, byte_in};
            2'd1:    asm_next[15:8] = byte_in;
            2'd2:    asm_next[23:16] = byte_in;
            default: asm_next = asm_reg;
        endcase
    end

    assign shape_ok_n = shape_ok_reg && !((pos_reg < 9'd4) && (byte_in != ddlw_pkg::START_BYTE));
    assign end_ok_n   = end_ok_reg && !(in_trailer && (byte_in != ddlw_pkg::END_BYTE));
    assign len_n      = (pos_reg == 9'd5) ? byte_in : len_reg;
    assign seq_n      = (pos_reg == 9'd4) ? byte_in : seq_reg;
    assign n          = {1'b0, pos_reg} + 10'd1;

    always_comb
    begin
        if ((n < 10'd4) || !shape_ok_n)
        begin
            code = ddlw_pkg::ERR_SHAPE;
        end
        else if ((n != ({2'd0, len_n} + 10'd10)) || (len_n[1:0] != 2'd0) ||
                 ({4'd0, len_n[7:2]} > 10'(MAX_WORDS)) || (n > 10'(BUF_BYTES)))
        begin
            code = ddlw_pkg::ERR_LENGTH;
        end
        else if (!end_ok_n)
        begin
            code = ddlw_pkg::ERR_SHAPE;
        end
        else
        begin
            code = ddlw_pkg::ERR_OK;
        end
    end

    assign frame_ok = cmd.finish && (code == ddlw_pkg::ERR_OK);
    assign expected = (({1'b0, last_seq_reg} + 9'd1) >= seq_mod_reg) ? 9'd0
                                                                     : {1'b0, last_seq_reg} + 9'd1;
    assign gap      = ({1'b0, seq_n} != expected);
    assign bad_inc  = (link_up_reg && (bad_reg != 8'd255)) ? bad_reg + 8'd1 : bad_reg;
    assign bad_new  = frame_ok ? 8'd0 : bad_inc;
    assign link_new = link_up_reg | frame_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            len_reg      <= '0;
            seq_reg      <= '0;
            shape_ok_reg <= 1'b1;
            end_ok_reg   <= 1'b1;
            asm_reg      <= '0;
        end
        else if (cmd.finish || cmd.timeout)
        begin
            pos_reg      <= '0;
            len_reg      <= '0;
            seq_reg      <= '0;
            shape_ok_reg <= 1'b1;
            end_ok_reg   <= 1'b1;
            asm_reg      <= '0;
        end
        else if (cmd.take)
        begin
            if (pos_reg != 9'd511)
            begin
                pos_reg <= pos_reg + 9'd1;
            end
            len_reg      <= len_n;
            seq_reg      <= seq_n;
            shape_ok_reg <= shape_ok_n;
            end_ok_reg   <= end_ok_n;
            if (in_payload)
            begin
                asm_reg <= asm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[w[AW-1:0]] <= {byte_in, asm_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg    <= '0;
            words_left_reg <= '0;
        end
        else if (cmd.finish || cmd.timeout)
        begin
            rd_addr_reg    <= '0;
            words_left_reg <= frame_ok ? CW'(len_n[7:2]) : '0;
        end
        else if (cmd.rd_en)
        begin
            rd_addr_reg    <= rd_addr_reg + AW'(1);
            words_left_reg <= words_left_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_limit_reg <= ddlw_pkg::LOSS_LIMIT_RESET;
            seq_mod_reg    <= ddlw_pkg::SEQ_MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddlw_pkg::REG_LOSS_LIMIT:  loss_limit_reg <= cfg_data[7:0];
                ddlw_pkg::REG_SEQ_MODULUS: seq_mod_reg    <= cfg_data;
                default:                   seq_mod_reg    <= seq_mod_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            link_up_reg  <= 1'b0;
            bad_reg      <= '0;
        end
        else if (cmd.finish || cmd.timeout)
        begin
            if (frame_ok)
            begin
                last_seq_reg <= seq_n;
            end
            link_up_reg <= link_new;
            bad_reg     <= bad_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish || cmd.timeout)
        begin
            st_valid_reg <= frame_ok;
            st_code_reg  <= cmd.timeout ? ddlw_pkg::ERR_TIMEOUT : code;
            st_gap_reg   <= frame_ok && gap;
            st_seq_reg   <= cmd.timeout ? 8'd0 : seq_n;
            st_conn_reg  <= link_new;
            st_bad_reg   <= bad_new;
            st_stop_reg  <= (bad_new > loss_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_word || cmd.load_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            out_kind_reg <= ddlw_pkg::KIND_WORD;
            out_last_reg <= 1'b0;
            out_data_reg <= {22'd0, rd_data_reg};
        end
        else if (cmd.load_status)
        begin
            out_kind_reg <= ddlw_pkg::KIND_STATUS;
            out_last_reg <= 1'b1;
            out_data_reg <= {st_stop_reg, st_bad_reg, st_conn_reg, st_seq_reg,
                             st_gap_reg, st_code_reg, st_valid_reg, 32'd0};
        end
    end

    assign stat.more_words = (words_left_reg != '0);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
